// ===== hw/rtl/mpps_pkg.sv =====
// package for the multi-policy process scheduler: sizes, codes and types
// used by the PRNG unit and the scheduler core
package mpps_pkg;

  localparam int unsigned NumProcs   = 5;
  localparam int unsigned MaxTickets = 128;
  localparam int unsigned PidW       = $clog2(NumProcs);
  localparam int unsigned TixIdxW    = $clog2(MaxTickets);
  localparam int unsigned TixCntW    = $clog2(MaxTickets + 1);
  localparam int unsigned DataW      = 32;
  localparam int unsigned SeedW      = 31;

  localparam logic [SeedW-1:0] SeedReset = 31'd123456789;
  localparam logic [14:0]      PmMult    = 15'd16807;

  typedef enum logic [2:0] {
    OP_SCHED   = 3'd0,
    OP_EXIT    = 3'd1,
    OP_SETPRIO = 3'd2,
    OP_SETSHR  = 3'd3,
    OP_ADDTIX  = 3'd4,
    OP_DELTIX  = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    POL_RR    = 3'd0,
    POL_LOWID = 3'd1,
    POL_PRIO  = 3'd2,
    POL_SHARE = 3'd3,
    POL_LOTT  = 3'd4
  } pol_e;

  typedef enum logic [1:0] {
    ST_EMPTY    = 2'd0,
    ST_RUNNABLE = 2'd1,
    ST_ZOMBIE   = 2'd2
  } pst_e;

  // request and status between the core and the modulo unit
  typedef struct packed {
    logic             start;
    logic [SeedW-1:0] seed;
    logic [TixCntW-1:0] total;
  } mod_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [SeedW-1:0]   seed;
    logic [TixIdxW-1:0] index;
  } mod_rsp_t;

  // initial ticket table: 5*p entries of pid p in pid order
  function automatic logic [PidW-1:0] init_ticket(input logic [TixIdxW-1:0] idx);
    int unsigned acc;
    logic [PidW-1:0] r;
    acc = 0;
    r = '0;
    for (int unsigned p = 1; p < NumProcs; p++) begin
      if (int'(idx) >= int'(acc) && int'(idx) < int'(acc + 5 * p)) r = PidW'(p);
      acc = acc + 5 * p;
    end
    return r;
  endfunction

  function automatic int unsigned init_total();
    int unsigned acc;
    acc = 0;
    for (int unsigned p = 1; p < NumProcs; p++) acc = acc + 5 * p;
    return (acc > MaxTickets) ? MaxTickets : acc;
  endfunction

endpackage

// ===== hw/rtl/mpps_ram.sv =====
// generic simple dual-port RAM (one write and one read port) with registered read
// no package dependency
module mpps_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== hw/rtl/mpps_lottery.sv =====
// lottery draw unit: park-miller seed step then seed mod ticket count
// one bit per cycle restoring reduction; uses mpps_pkg
module mpps_lottery (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mpps_pkg::mod_req_t req_i,
  output mpps_pkg::mod_rsp_t rsp_o
);
  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_RED  = 4'b0100,
    L_MOD  = 4'b1000
  } lst_e;

  lst_e state_q, state_d;
  logic [45:0] prod_q, prod_d;
  logic [mpps_pkg::SeedW-1:0] seed_q, seed_d;
  logic [mpps_pkg::TixCntW-1:0] tot_q, tot_d;
  logic [mpps_pkg::SeedW:0] rem_q, rem_d;
  logic [4:0] cnt_q, cnt_d;
  logic [mpps_pkg::SeedW:0] fold;
  logic [mpps_pkg::SeedW:0] shl;
  logic done;

  // 2^31 = 1 mod (2^31-1): fold high into low
  always_comb begin
    fold = {1'b0, prod_q[30:0]} + {1'b0, 16'd0, prod_q[45:31]};
  end

  assign shl = {rem_q[mpps_pkg::SeedW-1:0], seed_q[cnt_q]};

  always_comb begin
    state_d = state_q;
    prod_d  = prod_q;
    seed_d  = seed_q;
    tot_d   = tot_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    done    = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          prod_d  = 46'(req_i.seed) * 46'(mpps_pkg::PmMult);
          tot_d   = req_i.total;
          state_d = L_MUL;
        end
      end
      L_MUL: state_d = L_RED;
      L_RED: begin
        // fold result < 2^31+2^15: one subtract gives the residue
        if (fold >= {1'b0, 31'h7fffffff}) seed_d = 31'(fold - {1'b0, 31'h7fffffff});
        else seed_d = fold[mpps_pkg::SeedW-1:0];
        rem_d   = '0;
        cnt_d   = 5'(mpps_pkg::SeedW - 1);
        state_d = L_MOD;
      end
      L_MOD: begin
        if (shl >= 32'(tot_q)) rem_d = shl - 32'(tot_q);
        else rem_d = shl;
        if (cnt_q == '0) state_d = L_IDLE;
        cnt_d = cnt_q - 5'd1;
        done  = (cnt_q == '0);
      end
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      seed_q  <= mpps_pkg::SeedReset;
    end else begin
      state_q <= state_d;
      seed_q  <= seed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    tot_q  <= tot_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign rsp_o.done  = done;
  assign rsp_o.busy  = (state_q != L_IDLE);
  assign rsp_o.seed  = seed_q;
  // final remainder is the combinational value of the last step
  assign rsp_o.index = (shl >= 32'(tot_q)) ? mpps_pkg::TixIdxW'(shl - 32'(tot_q))
                                           : mpps_pkg::TixIdxW'(shl);
endmodule

// ===== hw/rtl/multi_policy_process_scheduler_core.sv =====
// top level of the multi-policy process scheduler
// uses mpps_pkg, mpps_ram and mpps_lottery
//
// Each event is handled by a sequencer from the input transfer until the
// result is offered: priority, share, add-ticket and unused-code events go
// straight to the result, round robin and lowest pid scan the process slots
// once, priority rotate first finds the least runnable priority over all
// slots and then scans, proportional share scans the slots at most twice, a
// lottery draw runs the seed multiply, a fold and a 31-step bit-serial modulo
// and then reads the drawn ticket RAM entry, and a ticket delete searches the
// ticket RAM down from the top entry and then shifts the later entries down.
// After reset the ticket RAM is filled with its initial contents, during
// which no event is accepted; policy writes are taken at any time.
module multi_policy_process_scheduler_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  run_pid_o,
  output logic        stalled_o
);
  localparam int unsigned PW = mpps_pkg::PidW;
  localparam int unsigned IW = mpps_pkg::TixIdxW;
  localparam int unsigned CW = mpps_pkg::TixCntW;

  typedef enum logic [10:0] {
    S_FILL  = 11'b00000000001,
    S_IDLE  = 11'b00000000010,
    S_MIN   = 11'b00000000100,
    S_SCAN  = 11'b00000001000,
    S_LOTW  = 11'b00000010000,
    S_LOTR  = 11'b00000100000,
    S_DSRCH = 11'b00001000000,
    S_DCHK  = 11'b00010000000,
    S_SHRD  = 11'b00100000000,
    S_SHWR  = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } st_e;

  st_e state_q, state_d;

  logic [2:0]  policy_q;
  logic [1:0]  status_q [mpps_pkg::NumProcs];
  logic [31:0] prio_q   [mpps_pkg::NumProcs];
  logic [31:0] share_q  [mpps_pkg::NumProcs];
  logic [31:0] runc_q   [mpps_pkg::NumProcs];
  logic [PW-1:0] cur_q, cur_d;
  logic [CW-1:0] total_q, total_d;
  logic [31:0] val_q;
  logic [PW-1:0] ptr_q, ptr_d;
  logic [4:0]  step_q, step_d;
  logic [31:0] least_q, least_d;
  logic [IW:0] idx_q, idx_d;
  logic        stall_q, stall_d;

  // process table write port (one slot per cycle)
  logic          pw_stat, pw_prio, pw_shr, pw_run;
  logic [PW-1:0] pw_idx;
  logic [1:0]    pw_sval;
  logic [31:0]   pw_dval, pw_rval;

  // ticket RAM
  logic          t_we;
  logic [IW-1:0] t_waddr, t_raddr;
  logic [PW-1:0] t_wdata, t_rdata;

  mpps_pkg::mod_req_t lreq;
  mpps_pkg::mod_rsp_t lrsp;

  mpps_ram #(.Width(PW), .Depth(mpps_pkg::MaxTickets)) u_tix (
    .clk_i, .we_i(t_we), .waddr_i(t_waddr), .wdata_i(t_wdata),
    .raddr_i(t_raddr), .rdata_o(t_rdata)
  );

  mpps_lottery u_lot (.clk_i, .rst_ni, .req_i(lreq), .rsp_o(lrsp));

  logic          accept;
  logic          runnable;
  logic [PW-1:0] nxt;
  assign accept   = in_valid_i && in_ready_o;
  assign runnable = (status_q[ptr_q] == mpps_pkg::ST_RUNNABLE);
  assign nxt      = (ptr_q == PW'(mpps_pkg::NumProcs - 1)) ? '0 : ptr_q + PW'(1);

  always_comb begin
    state_d = state_q;
    cur_d = cur_q; total_d = total_q; ptr_d = ptr_q; step_d = step_q;
    least_d = least_q; idx_d = idx_q; stall_d = stall_q;
    pw_stat = 1'b0; pw_prio = 1'b0; pw_shr = 1'b0; pw_run = 1'b0;
    pw_idx = cur_q; pw_sval = mpps_pkg::ST_ZOMBIE; pw_dval = val_q; pw_rval = val_q;
    t_we = 1'b0; t_waddr = idx_q[IW-1:0]; t_wdata = '0; t_raddr = idx_q[IW-1:0];
    lreq.start = 1'b0; lreq.seed = lrsp.seed; lreq.total = total_q;
    unique case (state_q)
      S_FILL: begin
        t_we = 1'b1;
        t_wdata = mpps_pkg::init_ticket(idx_q[IW-1:0]);
        idx_d = idx_q + 1'b1;
        if (idx_q == (IW+1)'(mpps_pkg::MaxTickets - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          stall_d = 1'b0;
          state_d = S_OUT;
          unique case (opcode_i)
            mpps_pkg::OP_SETPRIO: begin
              pw_prio = 1'b1; pw_dval = value_i;
            end
            mpps_pkg::OP_SETSHR: begin
              pw_shr = 1'b1; pw_run = 1'b1; pw_dval = value_i; pw_rval = value_i;
            end
            mpps_pkg::OP_ADDTIX: begin
              if (total_q < CW'(mpps_pkg::MaxTickets) &&
                  value_i < 32'(mpps_pkg::NumProcs)) begin
                t_we = 1'b1; t_waddr = total_q[IW-1:0]; t_wdata = value_i[PW-1:0];
                total_d = total_q + 1'b1;
              end
            end
            mpps_pkg::OP_DELTIX: begin
              idx_d = (IW+1)'(total_q);
              state_d = S_DSRCH;
            end
            mpps_pkg::OP_SCHED, mpps_pkg::OP_EXIT: begin
              if (opcode_i == mpps_pkg::OP_EXIT) pw_stat = 1'b1;
              least_d = 32'hffffffff;
              step_d  = '0;
              unique case (policy_q)
                mpps_pkg::POL_RR: begin
                  ptr_d = (cur_q == PW'(mpps_pkg::NumProcs - 1)) ? '0 : cur_q + PW'(1);
                  state_d = S_SCAN;
                end
                mpps_pkg::POL_LOWID: begin ptr_d = '0; state_d = S_SCAN; end
                mpps_pkg::POL_PRIO:  begin ptr_d = '0; state_d = S_MIN; end
                mpps_pkg::POL_SHARE: begin ptr_d = cur_q; state_d = S_SCAN; end
                mpps_pkg::POL_LOTT: begin
                  if (total_q == '0) stall_d = 1'b1;
                  else begin lreq.start = 1'b1; state_d = S_LOTW; end
                end
                default: stall_d = 1'b1;
              endcase
            end
            default: stall_d = 1'b1;
          endcase
        end
      end
      S_MIN: begin
        // least priority among runnable slots
        if (runnable && prio_q[ptr_q] < least_q) least_d = prio_q[ptr_q];
        ptr_d  = nxt;
        step_d = step_q + 5'd1;
        if (step_q == 5'(mpps_pkg::NumProcs - 1)) begin
          ptr_d = (cur_q == PW'(mpps_pkg::NumProcs - 1)) ? '0 : cur_q + PW'(1);
          step_d = '0;
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        ptr_d  = nxt;
        step_d = step_q + 5'd1;
        if (policy_q == mpps_pkg::POL_SHARE) begin
          if (runnable) begin
            pw_idx = ptr_q; pw_run = 1'b1;
            if (runc_q[ptr_q] == '0) pw_rval = share_q[ptr_q];
            else begin
              pw_rval = runc_q[ptr_q] - 32'd1;
              cur_d = ptr_q; state_d = S_OUT;
            end
          end
          if (state_d != S_OUT && step_q == 5'(2 * mpps_pkg::NumProcs - 1)) begin
            stall_d = 1'b1; state_d = S_OUT;
          end
        end else begin
          if (runnable && (policy_q != mpps_pkg::POL_PRIO || prio_q[ptr_q] <= least_q))
          begin
            cur_d = ptr_q; state_d = S_OUT;
          end else if (step_q == 5'(mpps_pkg::NumProcs - 1)) begin
            stall_d = 1'b1; state_d = S_OUT;
          end
        end
      end
      S_LOTW: begin
        if (lrsp.done) begin
          idx_d = {1'b0, lrsp.index};
          t_raddr = lrsp.index;
          state_d = S_LOTR;
        end
      end
      S_LOTR: begin
        // ram read of the drawn entry issued last cycle
        state_d = S_OUT;
        cur_d = t_rdata;
      end
      S_DSRCH: begin
        if (idx_q == '0) state_d = S_OUT;
        else begin
          idx_d = idx_q - 1'b1;
          t_raddr = IW'(idx_q - 1'b1);
          state_d = S_DCHK;
        end
      end
      S_DCHK: begin
        if (32'(t_rdata) == val_q) begin
          state_d = S_SHRD;
        end else state_d = S_DSRCH;
      end
      S_SHRD: begin
        // move entry idx+1 down to idx
        if ((idx_q + 1'b1) >= (IW+1)'(total_q)) begin
          total_d = total_q - 1'b1;
          state_d = S_OUT;
        end else begin
          t_raddr = IW'(idx_q + 1'b1);
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        t_we = 1'b1; t_waddr = idx_q[IW-1:0]; t_wdata = t_rdata;
        idx_d = idx_q + 1'b1;
        state_d = S_SHRD;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_FILL;
      policy_q <= mpps_pkg::POL_SHARE;
      cur_q    <= PW'(1);
      total_q  <= CW'(mpps_pkg::init_total());
      idx_q    <= '0;
      for (int i = 0; i < mpps_pkg::NumProcs; i++) begin
        status_q[i] <= (i == 0) ? mpps_pkg::ST_EMPTY : mpps_pkg::ST_RUNNABLE;
        prio_q[i]   <= 32'(i);
        share_q[i]  <= 32'(i);
        runc_q[i]   <= 32'(i);
      end
    end else begin
      state_q <= state_d;
      if (cfg_we_i) policy_q <= cfg_wdata_i;
      cur_q   <= cur_d;
      total_q <= total_d;
      idx_q   <= idx_d;
      if (pw_stat) status_q[pw_idx] <= pw_sval;
      if (pw_prio) prio_q[pw_idx]   <= pw_dval;
      if (pw_shr)  share_q[pw_idx]  <= pw_dval;
      if (pw_run)  runc_q[pw_idx]   <= pw_rval;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q   <= ptr_d;
    step_q  <= step_d;
    least_q <= least_d;
    stall_q <= stall_d;
    if (accept) begin
      val_q <= value_i;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign run_pid_o   = 3'(cur_q);
  assign stalled_o   = stall_q;

  a_ready_out_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(run_pid_o))
    else $error("result changed while stalled");
  a_pid_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q < PW'(mpps_pkg::NumProcs)) else $error("pid out of range");
  a_total_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(mpps_pkg::MaxTickets)) else $error("ticket count overflow");
  a_lot_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lrsp.busy |-> state_q == S_LOTW) else $error("draw running outside lottery wait");
endmodule
